// File: design/sln_pkg.sv
// Shared types, constants and IEEE single arithmetic helpers for the natural log pipeline.
// Depends on nothing; every other design file of the block imports it.
`timescale 1ns / 1ps
package sln_pkg;

  // Special bit patterns and range reduction constants.
  localparam logic [31:0] NegInf    = 32'hFF80_0000;
  localparam logic [31:0] PosInf    = 32'h7F80_0000;
  localparam logic [31:0] QNan      = 32'h7FC0_0000;
  localparam logic [31:0] SplitBits = 32'h3F2A_AAAB;
  localparam logic [31:0] ExpMask   = 32'hFF80_0000;
  localparam logic [31:0] MinNormal = 32'h0080_0000;
  localparam logic [31:0] MinusOne  = 32'hBF80_0000;
  localparam logic [31:0] Ln2       = 32'h3F31_7218;
  localparam logic [9:0]  SubCorr   = 10'h3E9;  // -23 in two's complement

  // Operation performed by one arithmetic stage.
  typedef enum logic [2:0] {
    OP_MUL_F_COEF,
    OP_ADD_COEF,
    OP_MUL_F_ACC,
    OP_ADD_F,
    OP_MUL_E_LN2,
    OP_ADD_E_ACC
  } sln_op_e;

  // Data carried along the pipeline with each beat.
  typedef struct packed {
    logic [31:0] f;
    logic [31:0] e;
    logic [31:0] acc;
    logic        spec;
    logic [31:0] spec_bits;
  } sln_data_t;

  localparam int NumSteps = 21;

  // Schedule of the polynomial and the final combine, one operation per stage.
  localparam sln_op_e StepOp [NumSteps] = '{
    OP_MUL_F_COEF, OP_ADD_COEF,
    OP_MUL_F_ACC,  OP_ADD_COEF,
    OP_MUL_F_ACC,  OP_ADD_COEF,
    OP_MUL_F_ACC,  OP_ADD_COEF,
    OP_MUL_F_ACC,  OP_ADD_COEF,
    OP_MUL_F_ACC,  OP_ADD_COEF,
    OP_MUL_F_ACC,  OP_ADD_COEF,
    OP_MUL_F_ACC,  OP_ADD_COEF,
    OP_MUL_F_ACC,
    OP_MUL_F_ACC,  OP_ADD_F,
    OP_MUL_E_LN2,  OP_ADD_E_ACC
  };

  localparam logic [31:0] StepCoef [NumSteps] = '{
    32'hBE05_5027, 32'h3E10_39F6,
    32'h0000_0000, 32'hBDF8_CDCC,
    32'h0000_0000, 32'h3E0F_2955,
    32'h0000_0000, 32'hBE2A_D8B9,
    32'h0000_0000, 32'h3E4C_ED0B,
    32'h0000_0000, 32'hBE7F_FF22,
    32'h0000_0000, 32'h3EAA_AA78,
    32'h0000_0000, 32'hBF00_0000,
    32'h0000_0000,
    32'h0000_0000, 32'h0000_0000,
    Ln2,           32'h0000_0000
  };

  // Leading zero count of a 27-bit word.
  function automatic logic [4:0] lzc27(input logic [26:0] v);
    logic [4:0] n;
    logic       found;
    n = 5'd0;
    found = 1'b0;
    for (int i = 26; i >= 0; i--) begin
      if (!found && v[i]) begin
        found = 1'b1;
        n = 5'(26 - i);
      end
    end
    return n;
  endfunction

  // Single precision multiply, round to nearest even; operands are normal or zero.
  function automatic logic [31:0] fp_mul(input logic [31:0] a, input logic [31:0] b);
    logic [47:0] prod;
    logic [9:0]  ex;
    logic [22:0] m;
    logic        g;
    logic        s;
    logic        inc;
    logic [30:0] mag;
    logic [31:0] r;
    prod = {1'b1, a[22:0]} * {1'b1, b[22:0]};
    ex = {2'b00, a[30:23]} + {2'b00, b[30:23]} - 10'd127;
    if (prod[47]) begin
      m  = prod[46:24];
      g  = prod[23];
      s  = |prod[22:0];
      ex = ex + 10'd1;
    end else begin
      m = prod[45:23];
      g = prod[22];
      s = |prod[21:0];
    end
    inc = g & (s | m[0]);
    mag = {ex[7:0], m} + {30'd0, inc};
    if (a[30:23] == 8'd0 || b[30:23] == 8'd0) begin
      r = {a[31] ^ b[31], 31'd0};
    end else begin
      r = {a[31] ^ b[31], mag};
    end
    return r;
  endfunction

  // Single precision add, round to nearest even; operands are normal or zero.
  function automatic logic [31:0] fp_add(input logic [31:0] a, input logic [31:0] b);
    logic [31:0] big;
    logic [31:0] sml;
    logic [7:0]  d;
    logic [49:0] ext;
    logic [26:0] mb;
    logic [26:0] ms;
    logic [27:0] sum;
    logic [26:0] nrm;
    logic [4:0]  lz;
    logic [9:0]  ex;
    logic        inc;
    logic [30:0] mag;
    logic [31:0] r;
    if (a[30:0] >= b[30:0]) begin
      big = a;
      sml = b;
    end else begin
      big = b;
      sml = a;
    end
    d   = big[30:23] - sml[30:23];
    mb  = {1'b1, big[22:0], 3'b000};
    ext = {1'b1, sml[22:0], 26'd0} >> d;
    ms  = {ext[49:24], ext[23] | (|ext[22:0])};
    if (d >= 8'd50) begin
      ms = 27'd1;
    end
    if (big[31] != sml[31]) begin
      sum = {1'b0, mb} - {1'b0, ms};
    end else begin
      sum = {1'b0, mb} + {1'b0, ms};
    end
    lz = 5'd0;
    if (sum[27]) begin
      nrm = {sum[27:2], sum[1] | sum[0]};
      ex  = {2'b00, big[30:23]} + 10'd1;
    end else begin
      lz  = lzc27(sum[26:0]);
      nrm = sum[26:0] << lz;
      ex  = {2'b00, big[30:23]} - {5'd0, lz};
    end
    inc = nrm[2] & (nrm[1] | nrm[0] | nrm[3]);
    mag = {ex[7:0], nrm[25:3]} + {30'd0, inc};
    // Zero operands pass through; exact cancellation gives plus zero.
    if (a[30:23] == 8'd0 && b[30:23] == 8'd0) begin
      r = {a[31] & b[31], 31'd0};
    end else if (a[30:23] == 8'd0) begin
      r = b;
    end else if (b[30:23] == 8'd0) begin
      r = a;
    end else if (sum == 28'd0) begin
      r = 32'd0;
    end else begin
      r = {big[31], mag};
    end
    return r;
  endfunction

  // Exact conversion of a small signed integer to single precision.
  function automatic logic [31:0] int10_to_fp(input logic [9:0] v);
    logic [9:0]  mg;
    logic [4:0]  lz;
    logic [9:0]  sh;
    logic [31:0] r;
    mg = v[9] ? (~v + 10'd1) : v;
    lz = lzc27({mg, 17'd0});
    sh = mg << lz;
    r  = {v[9], 8'(8'd136 - {3'd0, lz}), sh[8:0], 14'd0};
    if (v == 10'd0) begin
      r = 32'd0;
    end
    return r;
  endfunction

endpackage

// File: design/sln_front.sv
// Front end of the natural log pipeline: special cases, subnormal scaling,
// range reduction and the first rounded subtract. Depends on sln_pkg.
`timescale 1ns / 1ps
module sln_front (
  input  logic              clk_i,
  input  logic              rst_ni,
  input  logic              en_i,
  input  logic              valid_i,
  input  logic [31:0]       operand_bits_i,
  output logic              valid_o,
  output sln_pkg::sln_data_t data_o
);
  import sln_pkg::*;

  // Stage A: classify and normalize subnormal arguments.
  logic        a_valid_q;
  logic [31:0] a_xb_q, a_xb_d;
  logic        a_sub_q, a_sub_d;
  logic        a_spec_q, a_spec_d;
  logic [31:0] a_sbits_q, a_sbits_d;
  logic [4:0]  a_lz;
  logic [22:0] a_sh;

  always_comb begin
    a_spec_d  = 1'b1;
    a_sbits_d = 32'd0;
    if (operand_bits_i[30:0] == 31'd0) begin
      a_sbits_d = NegInf;
    end else if (operand_bits_i[31]) begin
      a_sbits_d = QNan;
    end else if (operand_bits_i > PosInf) begin
      a_sbits_d = QNan;
    end else if (operand_bits_i == PosInf) begin
      a_sbits_d = PosInf;
    end else begin
      a_spec_d = 1'b0;
    end
    a_sub_d = operand_bits_i < MinNormal;
    a_lz    = lzc27({operand_bits_i[22:0], 4'd0});
    a_sh    = operand_bits_i[22:0] << a_lz;
    a_xb_d  = operand_bits_i;
    if (a_sub_d) begin
      a_xb_d = {1'b0, 8'(8'd23 - {3'd0, a_lz}), a_sh[21:0], 1'b0};
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      a_valid_q <= 1'b0;
    end else if (en_i) begin
      a_valid_q <= valid_i;
    end
  end

  always_ff @(posedge clk_i) begin
    if (en_i) begin
      a_xb_q    <= a_xb_d;
      a_sub_q   <= a_sub_d;
      a_spec_q  <= a_spec_d;
      a_sbits_q <= a_sbits_d;
    end
  end

  // Stage B: split at two thirds into scale and mantissa.
  logic        b_valid_q;
  logic [31:0] b_mant_q, b_mant_d;
  logic [9:0]  b_eint_q, b_eint_d;
  logic        b_spec_q;
  logic [31:0] b_sbits_q;
  logic [31:0] b_scale;

  always_comb begin
    b_scale  = (a_xb_q - SplitBits) & ExpMask;
    b_mant_d = a_xb_q - b_scale;
    b_eint_d = {b_scale[31], b_scale[31:23]} + (a_sub_q ? SubCorr : 10'd0);
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      b_valid_q <= 1'b0;
    end else if (en_i) begin
      b_valid_q <= a_valid_q;
    end
  end

  always_ff @(posedge clk_i) begin
    if (en_i) begin
      b_mant_q  <= b_mant_d;
      b_eint_q  <= b_eint_d;
      b_spec_q  <= a_spec_q;
      b_sbits_q <= a_sbits_q;
    end
  end

  // Stage C: f = m - 1 and the exponent as a float.
  logic      c_valid_q;
  sln_data_t c_data_q, c_data_d;

  always_comb begin
    c_data_d.f         = fp_add(b_mant_q, MinusOne);
    c_data_d.e         = int10_to_fp(b_eint_q);
    c_data_d.acc       = 32'd0;
    c_data_d.spec      = b_spec_q;
    c_data_d.spec_bits = b_sbits_q;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      c_valid_q <= 1'b0;
    end else if (en_i) begin
      c_valid_q <= b_valid_q;
    end
  end

  always_ff @(posedge clk_i) begin
    if (en_i) begin
      c_data_q <= c_data_d;
    end
  end

  assign valid_o = c_valid_q;
  assign data_o  = c_data_q;

endmodule

// File: design/sln_fp_stage.sv
// One arithmetic stage of the natural log pipeline: a rounded multiply or add.
// Depends on sln_pkg for the data struct, the operation codes and the helpers.
`timescale 1ns / 1ps
module sln_fp_stage (
  input  logic               clk_i,
  input  logic               rst_ni,
  input  logic               en_i,
  input  sln_pkg::sln_op_e   op_i,
  input  logic [31:0]        coef_i,
  input  logic               valid_i,
  input  sln_pkg::sln_data_t data_i,
  output logic               valid_o,
  output sln_pkg::sln_data_t data_o
);
  import sln_pkg::*;

  logic      valid_q;
  sln_data_t data_q, data_d;

  // Select operands for this stage's operation.
  always_comb begin
    data_d = data_i;
    case (op_i)
      OP_MUL_F_COEF: data_d.acc = fp_mul(data_i.f, coef_i);
      OP_ADD_COEF:   data_d.acc = fp_add(data_i.acc, coef_i);
      OP_MUL_F_ACC:  data_d.acc = fp_mul(data_i.f, data_i.acc);
      OP_ADD_F:      data_d.acc = fp_add(data_i.acc, data_i.f);
      OP_MUL_E_LN2:  data_d.e   = fp_mul(data_i.e, coef_i);
      OP_ADD_E_ACC:  data_d.acc = fp_add(data_i.e, data_i.acc);
      default:       data_d = data_i;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      valid_q <= 1'b0;
    end else if (en_i) begin
      valid_q <= valid_i;
    end
  end

  always_ff @(posedge clk_i) begin
    if (en_i) begin
      data_q <= data_d;
    end
  end

  assign valid_o = valid_q;
  assign data_o  = data_q;

endmodule

// File: design/single_precision_natural_log.sv
// Top level of the single precision natural log pipeline.
// Depends on sln_pkg, sln_front and sln_fp_stage.
//
// Usage:
//   The input channel takes one IEEE single bit pattern per beat on
//   operand_bits_i; a beat is taken when valid_i is high and stall_o is low.
//   The output channel gives ln(x) as IEEE single bits on log_bits_o; a beat
//   is delivered when valid_o is high and stall_i is low.
//   Each accepted beat passes through three front-end stages (classification,
//   range reduction, m - 1) and 21 stages of one rounded multiply or add
//   each before its result reaches the output.
//   Throughput is one beat per cycle while the receiver does not stall; the
//   rounded add with its normalizing shift in the add stages sets the cycle time.
//   Reset clears every valid bit, so the pipeline comes up empty.
//   When the receiver stalls a valid result, the whole pipeline holds and
//   stall_o is raised; nothing is lost or repeated, and the held result
//   stays stable on the output.
`timescale 1ns / 1ps
module single_precision_natural_log (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        valid_i,
  output logic        stall_o,
  input  logic [31:0] operand_bits_i,
  output logic        valid_o,
  input  logic        stall_i,
  output logic [31:0] log_bits_o
);
  import sln_pkg::*;

  logic              en;
  logic [NumSteps:0] v;
  sln_data_t         d [NumSteps+1];

  // The pipeline advances unless a finished result is held by the receiver.
  assign en      = !(v[NumSteps] && stall_i);
  assign stall_o = v[NumSteps] && stall_i;

  sln_front u_front (
    .clk_i          (clk_i),
    .rst_ni         (rst_ni),
    .en_i           (en),
    .valid_i        (valid_i),
    .operand_bits_i (operand_bits_i),
    .valid_o        (v[0]),
    .data_o         (d[0])
  );

  // Polynomial and final combine, one rounded operation per stage.
  for (genvar i = 0; i < NumSteps; i++) begin : g_step
    sln_fp_stage u_stage (
      .clk_i   (clk_i),
      .rst_ni  (rst_ni),
      .en_i    (en),
      .op_i    (StepOp[i]),
      .coef_i  (StepCoef[i]),
      .valid_i (v[i]),
      .data_i  (d[i]),
      .valid_o (v[i+1]),
      .data_o  (d[i+1])
    );
  end

  assign valid_o    = v[NumSteps];
  assign log_bits_o = d[NumSteps].spec ? d[NumSteps].spec_bits : d[NumSteps].acc;

endmodule

// File: tb/tb.sv
// Self-checking testbench for the single precision natural log pipeline.
// It depends only on the design top level and checks each result against a bit-exact
// IEEE single predictor that is built from integer arithmetic.
`timescale 1ns / 1ps
module tb;

  // Encodings of the constants that the log evaluation uses.
  localparam logic [31:0] FpMinusOne  = 32'hBF80_0000;
  localparam logic [31:0] FpMinusHalf = 32'hBF00_0000;
  localparam logic [31:0] FpTwo23     = 32'h4B00_0000;
  localparam logic [31:0] FpTwoM23    = 32'h3400_0000;
  localparam logic [31:0] FpMinus23   = 32'hC1B8_0000;
  localparam logic [31:0] FpLn2       = 32'h3F31_7218;
  localparam logic [31:0] BitsNegInf  = 32'hFF80_0000;
  localparam logic [31:0] BitsPosInf  = 32'h7F80_0000;
  localparam logic [31:0] BitsQNan    = 32'h7FC0_0000;
  localparam logic [31:0] BitsSplit   = 32'h3F2A_AAAB;
  localparam logic [31:0] BitsExpMask = 32'hFF80_0000;
  localparam logic [31:0] BitsMinNorm = 32'h0080_0000;
  localparam int          CycleLimit  = 400000;
  localparam int          DrainCycles = 40;

  // Polynomial coefficients, highest order first; the first one multiplies f.
  localparam logic [31:0] PolyCoef [9] = '{
    32'hBE05_5027, 32'h3E10_39F6, 32'hBDF8_CDCC, 32'h3E0F_2955, 32'hBE2A_D8B9,
    32'h3E4C_ED0B, 32'hBE7F_FF22, 32'h3EAA_AA78, FpMinusHalf
  };

  logic        clk_i;
  logic        rst_ni;
  logic        valid_i;
  logic        stall_o;
  logic [31:0] operand_bits_i;
  logic        valid_o;
  logic        stall_i;
  logic [31:0] log_bits_o;

  logic [31:0] expected_logs[$];
  int          error_count;
  int          cycle_count;
  int          sent_count;
  int          checked_count;
  bit          calm;
  int          stall_left;

  single_precision_natural_log uut (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .valid_i       (valid_i),
    .stall_o       (stall_o),
    .operand_bits_i(operand_bits_i),
    .valid_o       (valid_o),
    .stall_i       (stall_i),
    .log_bits_o    (log_bits_o)
  );

  // Clock with a 20 ns period.
  initial clk_i = 1'b0;
  always #10 clk_i = ~clk_i;

  // Round a value mag * 2^scale to single precision, nearest even.
  function automatic logic [31:0] round_to_single(input logic sgn, input int scale,
                                                  input logic [127:0] mag);
    int          msb;
    int          sh;
    logic [127:0] keep;
    logic [127:0] rest;
    logic [127:0] half;
    msb = -1;
    for (int i = 0; i < 128; i++) begin
      if (mag[i]) msb = i;
    end
    if (msb < 0) return 32'd0;
    sh = msb - 23;
    if (sh > 0) begin
      keep = mag >> sh;
      rest = mag & ((128'd1 << sh) - 128'd1);
      half = 128'd1 << (sh - 1);
      if (rest > half || (rest == half && keep[0])) keep = keep + 128'd1;
      if (keep[24]) begin
        keep = keep >> 1;
        sh = sh + 1;
      end
    end else begin
      keep = mag << (-sh);
    end
    return {sgn, 8'(scale + sh + 23 + 127), keep[22:0]};
  endfunction

  // Rounded product of two normal-or-zero singles.
  function automatic logic [31:0] single_mul(input logic [31:0] a, input logic [31:0] b);
    logic [127:0] mag;
    if (a[30:23] == 8'd0 || b[30:23] == 8'd0) return {a[31] ^ b[31], 31'd0};
    mag = 128'({1'b1, a[22:0]}) * 128'({1'b1, b[22:0]});
    return round_to_single(a[31] ^ b[31],
                           int'(a[30:23]) + int'(b[30:23]) - 300, mag);
  endfunction

  // Rounded sum of two normal-or-zero singles; exact cancellation gives plus zero.
  function automatic logic [31:0] single_add(input logic [31:0] a, input logic [31:0] b);
    logic [31:0]  hi;
    logic [31:0]  lo;
    int           d;
    logic [127:0] mh;
    logic [127:0] ml;
    if (a[30:23] == 8'd0 && b[30:23] == 8'd0) return {a[31] & b[31], 31'd0};
    if (a[30:23] == 8'd0) return b;
    if (b[30:23] == 8'd0) return a;
    if (a[30:0] >= b[30:0]) begin
      hi = a;
      lo = b;
    end else begin
      hi = b;
      lo = a;
    end
    d = int'(hi[30:23]) - int'(lo[30:23]);
    mh = 128'({1'b1, hi[22:0]}) << 64;
    // A far smaller operand only matters as a sticky bit below the guard bits.
    if (d <= 64) ml = 128'({1'b1, lo[22:0]}) << (64 - d);
    else ml = 128'd1;
    if (hi[31] == lo[31]) mh = mh + ml;
    else mh = mh - ml;
    if (mh == 128'd0) return 32'd0;
    return round_to_single(hi[31], int'(hi[30:23]) - 150 - 64, mh);
  endfunction

  function automatic logic [31:0] mul_then_add(input logic [31:0] a, input logic [31:0] b,
                                               input logic [31:0] c);
    return single_add(single_mul(a, b), c);
  endfunction

  // Expected natural log bits of one operand.
  function automatic logic [31:0] natural_log_of(input logic [31:0] xb);
    logic [31:0] corr;
    logic [31:0] scale_bits;
    logic [31:0] f;
    logic [31:0] p;
    logic [31:0] e;
    logic [31:0] k_fp;
    logic [8:0]  k;
    if (xb[30:0] == 31'd0) return BitsNegInf;
    if (xb[31]) return BitsQNan;
    if (xb > BitsPosInf) return BitsQNan;
    if (xb == BitsPosInf) return BitsPosInf;
    corr = 32'd0;
    // Subnormal operands are scaled up by 2^23, which is exact.
    if (xb < BitsMinNorm) begin
      xb = round_to_single(1'b0, -126, 128'(xb[22:0]));
      corr = FpMinus23;
    end
    scale_bits = (xb - BitsSplit) & BitsExpMask;
    f = single_add(xb - scale_bits, FpMinusOne);
    k = scale_bits[31:23];
    p = mul_then_add(f, PolyCoef[0], PolyCoef[1]);
    for (int i = 2; i < 9; i++) begin
      p = mul_then_add(f, p, PolyCoef[i]);
    end
    p = single_mul(f, p);
    p = mul_then_add(f, p, f);
    k_fp = round_to_single(k[8], 0, 128'(k[8] ? -$signed(k) : $signed(k)));
    e = mul_then_add(single_mul(k_fp, FpTwo23), FpTwoM23, corr);
    return mul_then_add(e, FpLn2, p);
  endfunction

  // Receiver: random stall bursts, and each delivered beat checked in order.
  always @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      stall_i <= 1'b0;
      stall_left <= 0;
    end else begin
      if (valid_o && !stall_i) begin
        if (expected_logs.size() == 0) begin
          $error("unexpected beat: log_bits actual %h", log_bits_o);
          error_count++;
        end else begin
          if (log_bits_o !== expected_logs[0]) begin
            $error("log_bits mismatch: expected %h actual %h", expected_logs[0], log_bits_o);
            error_count++;
          end
          void'(expected_logs.pop_front());
          checked_count++;
        end
      end
      if (stall_left > 0) begin
        stall_left <= stall_left - 1;
        stall_i <= 1'b1;
      end else if (!calm && $urandom_range(0, 5) == 0) begin
        stall_left <= $urandom_range(0, 3);
        stall_i <= 1'b1;
      end else begin
        stall_i <= 1'b0;
      end
    end
  end

  // Watchdog on the whole run.
  always @(posedge clk_i) begin
    cycle_count++;
    if (cycle_count > CycleLimit) begin
      $display("simulation failed");
      $finish;
    end
  end

  // Send one beat, with an optional idle burst first; valid stays high afterwards.
  task automatic send_operand(input logic [31:0] bits);
    int gap;
    if (!calm && $urandom_range(0, 3) == 0) begin
      gap = $urandom_range(1, 4);
      valid_i <= 1'b0;
      repeat (gap) @(posedge clk_i);
    end
    valid_i <= 1'b1;
    operand_bits_i <= bits;
    do @(posedge clk_i); while (stall_o);
    expected_logs.push_back(natural_log_of(bits));
    sent_count++;
  endtask

  task automatic wait_for_results();
    valid_i <= 1'b0;
    while (expected_logs.size() != 0) @(posedge clk_i);
  endtask

  // Zeros, infinities, NaNs and negative operands.
  task automatic test_special_values();
    send_operand(32'h0000_0000);
    send_operand(32'h8000_0000);
    send_operand(BitsPosInf);
    send_operand(BitsNegInf);
    send_operand(32'h7F80_0001);
    send_operand(32'h7FC0_0000);
    send_operand(32'hFFFF_FFFF);
    send_operand(32'h8000_0001);
    send_operand(32'hBF80_0000);
  endtask

  // Smallest and largest subnormals and neighbors of the normal range.
  task automatic test_subnormal_operands();
    send_operand(32'h0000_0001);
    send_operand(32'h007F_FFFF);
    send_operand(32'h0040_0000);
    send_operand(BitsMinNorm);
    send_operand(32'h0080_0001);
  endtask

  // Values around one, the 2/3 split point and the top of the range.
  task automatic test_range_points();
    send_operand(32'h3F80_0000);
    send_operand(32'h3F7F_FFFF);
    send_operand(32'h3F80_0001);
    send_operand(BitsSplit);
    send_operand(BitsSplit - 32'd1);
    send_operand(32'h4000_0000);
    send_operand(32'h402D_F854);
    send_operand(32'h7F7F_FFFF);
    send_operand(32'h3F00_0000);
  endtask

  // Random operands weighted toward positive normals.
  task automatic test_random_operands(input int count);
    logic [31:0] bits;
    for (int i = 0; i < count; i++) begin
      case ($urandom_range(0, 9))
        0: bits = $urandom;
        1: bits = {9'd0, 23'($urandom)};
        2: bits = {$urandom_range(0, 1) == 0, 8'hFF, 23'($urandom_range(0, 3))};
        3: bits = {1'b0, 8'($urandom_range(120, 133)), 23'($urandom)};
        default: bits = {1'b0, 8'($urandom_range(1, 254)), 23'($urandom)};
      endcase
      send_operand(bits);
    end
  endtask

  initial begin
    error_count = 0;
    cycle_count = 0;
    sent_count = 0;
    checked_count = 0;
    calm = 1'b0;
    valid_i = 1'b0;
    operand_bits_i = 32'd0;
    rst_ni = 1'b0;
    repeat (4) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    test_special_values();
    test_subnormal_operands();
    test_range_points();
    // Let the pipeline drain completely once before the random traffic.
    wait_for_results();
    test_random_operands(380);
    // Final stretch streams back to back with no stalls.
    calm = 1'b1;
    test_random_operands(120);

    wait_for_results();
    repeat (DrainCycles) @(posedge clk_i);
    $display("Sent %0d operands covering zeros, infinities, NaNs, negatives,", sent_count);
    $display("subnormals and normals; %0d log results checked.", checked_count);
    if (error_count == 0 && expected_logs.size() == 0) begin
      $display("simulation ok");
    end else begin
      $display("simulation failed");
    end
    $finish;
  end

endmodule
